// ===== sv/interval_refine_engine_macros.svh =====
// Assertion macros for the interval refine engine.
`ifndef INTERVAL_REFINE_ENGINE_MACROS_SVH
`define INTERVAL_REFINE_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define IRE_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: label");
`define IRE_ASSERT_NEXT(label, clk, rst, cond, nxt) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error("%m");
`else
`define IRE_ASSERT_IMPL(label, clk, rst, prop)
`define IRE_ASSERT_NEXT(label, clk, rst, cond, nxt)
`endif
`endif

// ===== sv/ire_pkg.sv =====
package ire_pkg;

   localparam int unsigned ValueWidth = 32;

   typedef enum logic [3:0] {
      KIND_LOAD    = 4'd0,
      KIND_REFINE  = 4'd1,
      KIND_MIN     = 4'd2,
      KIND_MAX     = 4'd3,
      KIND_FIRST   = 4'd4,
      KIND_LAST    = 4'd5,
      KIND_SET     = 4'd6,
      KIND_MUL     = 4'd7,
      KIND_DIV     = 4'd8,
      KIND_MULDIVK = 4'd9,
      KIND_MULKDIV = 4'd10
   } kind_type;

   typedef enum logic [1:0] {
      OUT_UNCHANGED = 2'd0,
      OUT_CHANGED   = 2'd1,
      OUT_EMPTY     = 2'd2,
      OUT_REJECTED  = 2'd3
   } outcome_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_APPLY,
      ST_DONE
   } state_type;

   typedef enum logic [0:0] {
      REG_REAL_VALUED = 1'b0
   } reg_index_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [31:0] b_low;
      logic [31:0] b_high;
      logic        b_low_open;
      logic        b_high_open;
      logic [31:0] c_low;
      logic [31:0] c_high;
      logic        c_low_open;
      logic        c_high_open;
      logic [31:0] scalar;
   } req_type;

   typedef struct packed {
      logic [31:0] res_low;
      logic [31:0] res_high;
      logic        res_low_open;
      logic        res_high_open;
      logic        res_empty;
      logic [1:0]  outcome;
   } rsp_type;

endpackage

// ===== sv/interval_refine_engine.sv =====
// Load, refine, min, max, first, last, set and unused kinds go straight from idle to
// done. Mul, div, muldivk and mulkdiv run, for each end, a bit-serial product, a
// restoring divide (not for mul) and the apply state, on hardware shared by both ends.
// One transaction at a time: req_stall holds off the next until the result is taken.
// Reset (synchronous, active high): [0, all ones] closed, not empty, real_valued 0, idle.
`include "interval_refine_engine_macros.svh"

module interval_refine_engine #(
   parameter int unsigned VALUE_WIDTH = ire_pkg::ValueWidth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ire_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ire_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   localparam int unsigned W  = VALUE_WIDTH;
   localparam int unsigned W2 = 2 * VALUE_WIDTH;
   localparam int unsigned CW = $clog2(W2 + 1);
   localparam logic [W-1:0] VMAX = {W{1'b1}};

   // Stored interval.
   logic [W-1:0] low_ff, low_in, high_ff, high_in;
   logic         lopen_ff, lopen_in, hopen_ff, hopen_in, empty_ff, empty_in;
   logic         real_ff;

   // Transaction in flight.
   ire_pkg::state_type state_ff, state_in;
   ire_pkg::req_type   req_ff, req_in;
   logic               side_ff, side_in;        // 0 lower end, 1 upper end
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [W2-1:0]      acc_ff, acc_in;          // product, then quotient
   logic [W2-1:0]      mcand_ff, mcand_in;
   logic [W-1:0]       mplier_ff, mplier_in;
   logic [W:0]         rem_ff, rem_in;
   logic [W-1:0]       tlo_ff, tlo_in, thi_ff, thi_in;
   logic               tlo_open_ff, tlo_open_in, thi_open_ff, thi_open_in;
   ire_pkg::rsp_type   rsp_ff, rsp_in;

   // Configuration port.
   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         real_ff <= 1'b0;
      end else if (psel && penable && pwrite && paddr[2] == ire_pkg::REG_REAL_VALUED) begin
         real_ff <= pwdata[0];
      end
   end
   always_comb begin
      prdata = '0;
      if (paddr[2] == ire_pkg::REG_REAL_VALUED) begin
         prdata[0] = real_ff;
      end
   end

   assign req_stall = (state_ff != ire_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == ire_pkg::ST_DONE);
   assign rsp_data  = rsp_ff;

   // Operand values narrowed to the configured width.
   logic [W-1:0] bl, bh, cl, kk, q_bh, q_cl, q_ch, q_k;
   assign bl = req_data.b_low[W-1:0];
   assign bh = req_data.b_high[W-1:0];
   assign cl = req_data.c_low[W-1:0];
   assign kk = req_data.scalar[W-1:0];
   assign q_bh = req_ff.b_high[W-1:0];
   assign q_cl = req_ff.c_low[W-1:0];
   assign q_ch = req_ff.c_high[W-1:0];
   assign q_k  = req_ff.scalar[W-1:0];

   // Divisor of the end being computed.
   logic [W-1:0] op_d;
   always_comb begin
      op_d = '0;
      unique case (ire_pkg::kind_type'(req_ff.kind))
         ire_pkg::KIND_MUL: begin
            op_d = '0;
         end
         ire_pkg::KIND_DIV: begin
            op_d = side_ff ? q_cl : q_ch;
         end
         ire_pkg::KIND_MULDIVK: begin
            op_d = q_k;
         end
         default: begin
            op_d = side_ff ? q_cl : q_ch;
         end
      endcase
   end

   // One restoring divide step on the partial remainder.
   logic [W:0]   rem_shift;
   logic         rem_ge;
   assign rem_shift = {rem_ff[W-1:0], acc_ff[W2-1]};
   assign rem_ge    = rem_shift >= {1'b0, op_d};

   // Narrowing helpers.
   function automatic void narrow_low(inout logic [W-1:0] lo, inout logic lo_o,
                                      input logic [W-1:0] v, input logic vo);
      if (lo < v) begin
         lo = v;
         lo_o = vo;
      end else if (lo == v && !lo_o && vo) begin
         lo_o = 1'b1;
      end
   endfunction

   function automatic void narrow_high(inout logic [W-1:0] hi, inout logic hi_o,
                                       input logic [W-1:0] v, input logic vo);
      if (hi > v) begin
         hi = v;
         hi_o = vo;
      end else if (hi == v && !hi_o && vo) begin
         hi_o = 1'b1;
      end
   endfunction

   function automatic logic tighten(inout logic [W-1:0] lo, inout logic lo_o,
                                    inout logic [W-1:0] hi, inout logic hi_o,
                                    input logic rv);
      if (!rv) begin
         if (lo_o && lo != VMAX) begin
            lo = lo + 1'b1;
            lo_o = 1'b0;
         end
         if (hi_o && hi != '0) begin
            hi = hi - 1'b1;
            hi_o = 1'b0;
         end
      end
      return (lo > hi) || (lo == hi && (lo_o || hi_o));
   endfunction

   // Sequencer and update of the stored interval.
   logic [W-1:0] s_lo, s_hi, qv, ub;
   logic         s_lo_o, s_hi_o, emp, prem, qsat, ub_o;
   ire_pkg::outcome_type oc;
   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      side_in = side_ff;
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      mcand_in = mcand_ff;
      mplier_in = mplier_ff;
      rem_in = rem_ff;
      tlo_in = tlo_ff;
      thi_in = thi_ff;
      tlo_open_in = tlo_open_ff;
      thi_open_in = thi_open_ff;
      rsp_in = rsp_ff;
      low_in = low_ff;
      high_in = high_ff;
      lopen_in = lopen_ff;
      hopen_in = hopen_ff;
      empty_in = empty_ff;
      s_lo = low_ff;
      s_hi = high_ff;
      s_lo_o = lopen_ff;
      s_hi_o = hopen_ff;
      emp = empty_ff;
      oc = ire_pkg::OUT_UNCHANGED;
      qv = '0;
      prem = 1'b0;
      qsat = 1'b0;
      ub = '0;
      ub_o = 1'b0;
      unique case (state_ff)
         ire_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               ub = (kk == VMAX) ? VMAX : kk + 1'b1;
               ub_o = (kk != VMAX);
               if (req_data.kind > ire_pkg::KIND_MULKDIV) begin
                  oc = ire_pkg::OUT_UNCHANGED;
               end else if (req_data.kind != ire_pkg::KIND_LOAD && empty_ff) begin
                  oc = ire_pkg::OUT_REJECTED;
               end else begin
                  unique case (ire_pkg::kind_type'(req_data.kind))
                     ire_pkg::KIND_LOAD: begin
                        s_lo = bl;
                        s_hi = bh;
                        s_lo_o = req_data.b_low_open;
                        s_hi_o = req_data.b_high_open;
                        emp = tighten(s_lo, s_lo_o, s_hi, s_hi_o, real_ff);
                     end
                     ire_pkg::KIND_REFINE: begin
                        narrow_low(s_lo, s_lo_o, bl, req_data.b_low_open);
                        narrow_high(s_hi, s_hi_o, bh, req_data.b_high_open);
                        emp = tighten(s_lo, s_lo_o, s_hi, s_hi_o, real_ff);
                     end
                     ire_pkg::KIND_MIN: begin
                        narrow_low(s_lo, s_lo_o, kk, 1'b0);
                        emp = tighten(s_lo, s_lo_o, s_hi, s_hi_o, real_ff);
                     end
                     ire_pkg::KIND_MAX: begin
                        narrow_high(s_hi, s_hi_o, ub, ub_o);
                        emp = tighten(s_lo, s_lo_o, s_hi, s_hi_o, real_ff);
                     end
                     ire_pkg::KIND_SET: begin
                        narrow_low(s_lo, s_lo_o, kk, 1'b0);
                        narrow_high(s_hi, s_hi_o, ub, ub_o);
                        emp = tighten(s_lo, s_lo_o, s_hi, s_hi_o, real_ff);
                     end
                     ire_pkg::KIND_FIRST, ire_pkg::KIND_LAST: begin
                        emp = 1'b0;
                        if (!(low_ff == high_ff || (low_ff + 1'b1 == high_ff &&
                              {1'b0, low_ff} != {1'b0, VMAX} && lopen_ff && hopen_ff))) begin
                           if (req_data.kind == ire_pkg::KIND_FIRST) begin
                              s_hi = low_ff;
                              s_hi_o = lopen_ff;
                              if (lopen_ff && low_ff != VMAX) begin
                                 s_hi = low_ff + 1'b1;
                              end
                           end else begin
                              s_lo = high_ff;
                              s_lo_o = hopen_ff;
                              if (hopen_ff && high_ff != '0) begin
                                 s_lo = high_ff - 1'b1;
                              end
                           end
                        end
                     end
                     default: begin
                     end
                  endcase
               end
               if (req_data.kind >= ire_pkg::KIND_MUL &&
                   req_data.kind <= ire_pkg::KIND_MULKDIV && !empty_ff) begin
                  // Arithmetic kinds: start the lower end's product.
                  side_in = 1'b0;
                  acc_in = '0;
                  cnt_in = '0;
                  mcand_in = {{W{1'b0}}, bl};
                  unique case (ire_pkg::kind_type'(req_data.kind))
                     ire_pkg::KIND_MUL: mplier_in = cl;
                     ire_pkg::KIND_DIV: mplier_in = {{(W-1){1'b0}}, 1'b1};
                     ire_pkg::KIND_MULDIVK: mplier_in = cl;
                     default: mplier_in = kk;
                  endcase
                  state_in = ire_pkg::ST_MUL;
               end else begin
                  if (req_data.kind <= ire_pkg::KIND_MULKDIV && !(req_data.kind !=
                      ire_pkg::KIND_LOAD && empty_ff)) begin
                     if (emp) begin
                        oc = ire_pkg::OUT_EMPTY;
                     end else if (s_lo != low_ff || s_hi != high_ff || s_lo_o != lopen_ff ||
                                  s_hi_o != hopen_ff || emp != empty_ff) begin
                        oc = ire_pkg::OUT_CHANGED;
                     end
                     low_in = s_lo;
                     high_in = s_hi;
                     lopen_in = s_lo_o;
                     hopen_in = s_hi_o;
                     empty_in = emp;
                  end
                  rsp_in = '0;
                  rsp_in.res_low = 32'(s_lo);
                  rsp_in.res_high = 32'(s_hi);
                  rsp_in.res_low_open = s_lo_o;
                  rsp_in.res_high_open = s_hi_o;
                  rsp_in.res_empty = emp;
                  rsp_in.outcome = oc;
                  if (req_data.kind > ire_pkg::KIND_MULKDIV ||
                      (req_data.kind != ire_pkg::KIND_LOAD && empty_ff)) begin
                     rsp_in.res_low = 32'(low_ff);
                     rsp_in.res_high = 32'(high_ff);
                     rsp_in.res_low_open = lopen_ff;
                     rsp_in.res_high_open = hopen_ff;
                     rsp_in.res_empty = empty_ff;
                  end
                  state_in = ire_pkg::ST_DONE;
               end
            end
         end
         // Shift-add product, one multiplier bit per cycle.
         ire_pkg::ST_MUL: begin
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in = {mcand_ff[W2-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[W-1:1]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(W - 1)) begin
               cnt_in = '0;
               rem_in = '0;
               if (req_ff.kind == ire_pkg::KIND_MUL) begin
                  state_in = ire_pkg::ST_APPLY;
               end else begin
                  state_in = ire_pkg::ST_DIV;
               end
            end
         end
         // Restoring division, one quotient bit per cycle.
         ire_pkg::ST_DIV: begin
            if (rem_ge) begin
               rem_in = rem_shift - {1'b0, op_d};
            end else begin
               rem_in = rem_shift;
            end
            acc_in = {acc_ff[W2-2:0], rem_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(W2 - 1)) begin
               cnt_in = '0;
               state_in = ire_pkg::ST_APPLY;
            end
         end
         // Saturate, record one end, then either start the other end or finish.
         ire_pkg::ST_APPLY: begin
            if (req_ff.kind == ire_pkg::KIND_MUL) begin
               qsat = (acc_ff[W2-1:W] != '0);
               qv = qsat ? VMAX : acc_ff[W-1:0];
               prem = 1'b0;
            end else begin
               qsat = (op_d == '0) || (acc_ff[W2-1:W] != '0) || (acc_ff[W-1:0] == VMAX);
               qv = qsat ? VMAX : acc_ff[W-1:0];
               prem = !qsat && (rem_ff != '0);
            end
            if (!side_ff) begin
               tlo_in = qv;
               if (req_ff.kind == ire_pkg::KIND_MUL || req_ff.kind == ire_pkg::KIND_MULDIVK) begin
                  tlo_open_in = prem || req_ff.b_low_open || req_ff.c_low_open;
               end else begin
                  tlo_open_in = prem || req_ff.b_low_open || req_ff.c_high_open;
               end
               side_in = 1'b1;
               acc_in = '0;
               mcand_in = {{W{1'b0}}, q_bh};
               unique case (ire_pkg::kind_type'(req_ff.kind))
                  ire_pkg::KIND_MUL: mplier_in = q_ch;
                  ire_pkg::KIND_DIV: mplier_in = {{(W-1){1'b0}}, 1'b1};
                  ire_pkg::KIND_MULDIVK: mplier_in = q_ch;
                  default: mplier_in = q_k;
               endcase
               state_in = ire_pkg::ST_MUL;
            end else begin
               if (prem) begin
                  thi_in = qv + 1'b1;
                  thi_open_in = 1'b1;
               end else begin
                  thi_in = qv;
                  if (req_ff.kind == ire_pkg::KIND_MUL || req_ff.kind == ire_pkg::KIND_MULDIVK) begin
                     thi_open_in = req_ff.b_high_open || req_ff.c_high_open;
                  end else begin
                     thi_open_in = req_ff.b_high_open || req_ff.c_low_open;
                  end
               end
               narrow_low(s_lo, s_lo_o, tlo_ff, tlo_open_ff);
               narrow_high(s_hi, s_hi_o, thi_in, thi_open_in);
               emp = tighten(s_lo, s_lo_o, s_hi, s_hi_o, real_ff);
               if (emp) begin
                  oc = ire_pkg::OUT_EMPTY;
               end else if (s_lo != low_ff || s_hi != high_ff || s_lo_o != lopen_ff ||
                            s_hi_o != hopen_ff || emp != empty_ff) begin
                  oc = ire_pkg::OUT_CHANGED;
               end
               low_in = s_lo;
               high_in = s_hi;
               lopen_in = s_lo_o;
               hopen_in = s_hi_o;
               empty_in = emp;
               rsp_in.res_low = 32'(s_lo);
               rsp_in.res_high = 32'(s_hi);
               rsp_in.res_low_open = s_lo_o;
               rsp_in.res_high_open = s_hi_o;
               rsp_in.res_empty = emp;
               rsp_in.outcome = oc;
               state_in = ire_pkg::ST_DONE;
            end
         end
         ire_pkg::ST_DONE: begin
            if (!rsp_stall) begin
               state_in = ire_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ire_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ire_pkg::ST_IDLE;
         low_ff <= '0;
         high_ff <= VMAX;
         lopen_ff <= 1'b0;
         hopen_ff <= 1'b0;
         empty_ff <= 1'b0;
         side_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         low_ff <= low_in;
         high_ff <= high_in;
         lopen_ff <= lopen_in;
         hopen_ff <= hopen_in;
         empty_ff <= empty_in;
         side_ff <= side_in;
         cnt_ff <= cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      acc_ff <= acc_in;
      mcand_ff <= mcand_in;
      mplier_ff <= mplier_in;
      rem_ff <= rem_in;
      tlo_ff <= tlo_in;
      thi_ff <= thi_in;
      tlo_open_ff <= tlo_open_in;
      thi_open_ff <= thi_open_in;
      rsp_ff <= rsp_in;
   end

   // An empty outcome always comes with the empty flag set in the result.
   `IRE_ASSERT_IMPL(a_empty_outcome, clock, reset, rsp_valid && rsp_data.outcome == ire_pkg::OUT_EMPTY |-> rsp_data.res_empty)
   // A rejected transaction leaves the interval empty.
   `IRE_ASSERT_IMPL(a_reject_keeps, clock, reset, rsp_valid && rsp_data.outcome == ire_pkg::OUT_REJECTED |-> empty_ff)
   // The step counter never runs past the dividend width.
   `IRE_ASSERT_IMPL(a_count_range, clock, reset, 1'b1 |-> cnt_ff <= CW'(W2 - 1))
   // The empty flag holds steady while a product or divide step runs.
   `IRE_ASSERT_NEXT(a_state_hold, clock, reset, state_ff == ire_pkg::ST_MUL || state_ff == ire_pkg::ST_DIV, $stable(empty_ff))

endmodule

// ===== tb/interval_refine_engine_test.sv =====
`timescale 1ns / 1ps

module interval_refine_engine_test;

   localparam logic [31:0] TopValue = 32'hFFFF_FFFF;
   localparam int unsigned RandomItems = 730;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   ire_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   ire_pkg::rsp_type rsp_data;
   logic             psel;
   logic             penable;
   logic             pwrite;
   logic [2:0]       paddr;
   logic [31:0]      pwdata;
   logic [31:0]      prdata;
   logic             pready;

   interval_refine_engine dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Shadow copy of the stored interval and mode register.
   logic [31:0] ivl_low;
   logic [31:0] ivl_high;
   logic        ivl_low_open;
   logic        ivl_high_open;
   logic        ivl_empty;
   logic        real_mode;

   ire_pkg::rsp_type expected_results[$];
   int unsigned mismatch_count;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned hold_off_cycles;
   int unsigned sent_items;

   typedef struct {
      ire_pkg::req_type req;
      logic             has_expected;
      ire_pkg::rsp_type rsp;
   } stim_row_type;

   stim_row_type directed_rows[$];

   // Clock generation.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Open ends are widened to a 33-bit view so that the edge cases stay exact.
   function automatic void narrow_low(inout logic [32:0] lo, inout logic lo_open,
                                      input logic [32:0] v, input logic v_open);
      if (lo < v) begin
         lo = v;
         lo_open = v_open;
      end else if (lo == v && !lo_open && v_open) begin
         lo_open = 1'b1;
      end
   endfunction

   function automatic void narrow_high(inout logic [32:0] hi, inout logic hi_open,
                                       input logic [32:0] v, input logic v_open);
      if (hi > v) begin
         hi = v;
         hi_open = v_open;
      end else if (hi == v && !hi_open && v_open) begin
         hi_open = 1'b1;
      end
   endfunction

   function automatic logic tighten(inout logic [32:0] lo, inout logic lo_open,
                                    inout logic [32:0] hi, inout logic hi_open);
      if (!real_mode) begin
         if (lo_open && lo < {1'b0, TopValue}) begin
            lo = lo + 33'd1;
            lo_open = 1'b0;
         end
         if (hi_open && hi > 33'd0) begin
            hi = hi - 33'd1;
            hi_open = 1'b0;
         end
      end
      return (lo > hi) || (lo == hi && (lo_open || hi_open));
   endfunction

   function automatic logic [32:0] sat_product(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] p;
      p = 64'(a) * 64'(b);
      return (p > 64'(TopValue)) ? {1'b0, TopValue} : {1'b0, p[31:0]};
   endfunction

   function automatic logic [32:0] scaled_quotient(input logic [31:0] a, input logic [31:0] b,
                                                   input logic [31:0] d, output logic rem);
      logic [63:0] n;
      logic [63:0] q;
      n = 64'(a) * 64'(b);
      rem = 1'b0;
      if (d == 32'd0) return {1'b0, TopValue};
      q = n / 64'(d);
      if (q >= 64'(TopValue)) return {1'b0, TopValue};
      rem = (n % 64'(d)) != 64'd0;
      return {1'b0, q[31:0]};
   endfunction

   // Computes the result of one transaction and advances the shadow interval.
   function automatic ire_pkg::rsp_type next_interval(input ire_pkg::req_type r);
      ire_pkg::rsp_type res;
      logic [32:0] lo;
      logic [32:0] hi;
      logic [32:0] tl;
      logic [32:0] th;
      logic        lo_open;
      logic        hi_open;
      logic        tl_open;
      logic        th_open;
      logic        emp;
      logic        rem;
      logic        computed;
      logic [1:0]  result_code;
      lo = {1'b0, ivl_low};
      hi = {1'b0, ivl_high};
      lo_open = ivl_low_open;
      hi_open = ivl_high_open;
      emp = ivl_empty;
      computed = 1'b0;
      tl = '0;
      th = '0;
      tl_open = 1'b0;
      th_open = 1'b0;
      if (r.kind > ire_pkg::KIND_MULKDIV) begin
         result_code = ire_pkg::OUT_UNCHANGED;
      end else if (r.kind != ire_pkg::KIND_LOAD && ivl_empty) begin
         result_code = ire_pkg::OUT_REJECTED;
      end else begin
         case (r.kind)
            ire_pkg::KIND_LOAD: begin
               lo = {1'b0, r.b_low};
               hi = {1'b0, r.b_high};
               lo_open = r.b_low_open;
               hi_open = r.b_high_open;
               emp = tighten(lo, lo_open, hi, hi_open);
            end
            ire_pkg::KIND_REFINE: begin
               tl = {1'b0, r.b_low};
               th = {1'b0, r.b_high};
               tl_open = r.b_low_open;
               th_open = r.b_high_open;
               computed = 1'b1;
            end
            ire_pkg::KIND_MIN, ire_pkg::KIND_MAX, ire_pkg::KIND_SET: begin
               if (r.kind != ire_pkg::KIND_MAX)
                  narrow_low(lo, lo_open, {1'b0, r.scalar}, 1'b0);
               if (r.kind != ire_pkg::KIND_MIN) begin
                  if (r.scalar < TopValue) narrow_high(hi, hi_open, {1'b0, r.scalar} + 33'd1, 1'b1);
                  else narrow_high(hi, hi_open, {1'b0, TopValue}, 1'b0);
               end
               emp = tighten(lo, lo_open, hi, hi_open);
            end
            ire_pkg::KIND_FIRST, ire_pkg::KIND_LAST: begin
               emp = 1'b0;
               if (!(lo == hi || (lo + 33'd1 == hi && lo_open && hi_open))) begin
                  if (r.kind == ire_pkg::KIND_FIRST) begin
                     hi = lo;
                     hi_open = lo_open;
                     if (hi_open && hi < {1'b0, TopValue}) hi = hi + 33'd1;
                  end else begin
                     lo = hi;
                     lo_open = hi_open;
                     if (lo_open && lo > 33'd0) lo = lo - 33'd1;
                  end
               end
            end
            ire_pkg::KIND_MUL: begin
               tl = sat_product(r.b_low, r.c_low);
               th = sat_product(r.b_high, r.c_high);
               tl_open = r.b_low_open || r.c_low_open;
               th_open = r.b_high_open || r.c_high_open;
               computed = 1'b1;
            end
            default: begin
               // Division family: for div and mulkdiv the quotient's low end uses the divisor's high end.
               if (r.kind == ire_pkg::KIND_DIV) begin
                  tl = scaled_quotient(r.b_low, 32'd1, r.c_high, rem);
                  tl_open = rem || r.b_low_open || r.c_high_open;
                  th = scaled_quotient(r.b_high, 32'd1, r.c_low, rem);
                  th_open = r.b_high_open || r.c_low_open;
               end else if (r.kind == ire_pkg::KIND_MULDIVK) begin
                  tl = scaled_quotient(r.b_low, r.c_low, r.scalar, rem);
                  tl_open = rem || r.b_low_open || r.c_low_open;
                  th = scaled_quotient(r.b_high, r.c_high, r.scalar, rem);
                  th_open = r.b_high_open || r.c_high_open;
               end else begin
                  tl = scaled_quotient(r.b_low, r.scalar, r.c_high, rem);
                  tl_open = rem || r.b_low_open || r.c_high_open;
                  th = scaled_quotient(r.b_high, r.scalar, r.c_low, rem);
                  th_open = r.b_high_open || r.c_low_open;
               end
               if (rem) begin
                  th = th + 33'd1;
                  th_open = 1'b1;
               end
               computed = 1'b1;
            end
         endcase
         if (computed) begin
            narrow_low(lo, lo_open, tl, tl_open);
            narrow_high(hi, hi_open, th, th_open);
            emp = tighten(lo, lo_open, hi, hi_open);
         end
         if (emp) result_code = ire_pkg::OUT_EMPTY;
         else if (lo[31:0] != ivl_low || hi[31:0] != ivl_high || lo_open != ivl_low_open ||
                  hi_open != ivl_high_open || emp != ivl_empty)
            result_code = ire_pkg::OUT_CHANGED;
         else result_code = ire_pkg::OUT_UNCHANGED;
         ivl_low = lo[31:0];
         ivl_high = hi[31:0];
         ivl_low_open = lo_open;
         ivl_high_open = hi_open;
         ivl_empty = emp;
      end
      res.res_low = ivl_low;
      res.res_high = ivl_high;
      res.res_low_open = ivl_low_open;
      res.res_high_open = ivl_high_open;
      res.res_empty = ivl_empty;
      res.outcome = result_code;
      return res;
   endfunction

   function automatic ire_pkg::req_type make_req(input logic [3:0] k,
                                                 input logic [31:0] bl, input logic [31:0] bh,
                                                 input logic blo, input logic bho,
                                                 input logic [31:0] cl, input logic [31:0] ch,
                                                 input logic clo, input logic cho,
                                                 input logic [31:0] sc);
      ire_pkg::req_type r;
      r.kind = k;
      r.b_low = bl;
      r.b_high = bh;
      r.b_low_open = blo;
      r.b_high_open = bho;
      r.c_low = cl;
      r.c_high = ch;
      r.c_low_open = clo;
      r.c_high_open = cho;
      r.scalar = sc;
      return r;
   endfunction

   function automatic ire_pkg::rsp_type make_rsp(input logic [31:0] lo, input logic [31:0] hi,
                                                 input logic lo_open, input logic hi_open,
                                                 input logic emp,
                                                 input ire_pkg::outcome_type oc);
      ire_pkg::rsp_type r;
      r.res_low = lo;
      r.res_high = hi;
      r.res_low_open = lo_open;
      r.res_high_open = hi_open;
      r.res_empty = emp;
      r.outcome = oc;
      return r;
   endfunction

   function automatic logic [31:0] random_value();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return TopValue;
         2: return 32'($urandom_range(0, 20));
         3: return TopValue - 32'($urandom_range(0, 20));
         4: return 32'($urandom_range(0, 65535));
         default: return $urandom();
      endcase
   endfunction

   // Mostly a load of a fresh interval followed by a few narrowing steps.
   function automatic ire_pkg::req_type random_req(input logic start_fresh);
      ire_pkg::req_type r;
      logic [31:0]      a;
      logic [31:0]      b;
      r = '0;
      r.b_low_open = 1'($urandom());
      r.b_high_open = 1'($urandom());
      r.c_low_open = 1'($urandom());
      r.c_high_open = 1'($urandom());
      a = random_value();
      b = random_value();
      r.b_low = (a < b) ? a : b;
      r.b_high = (a < b) ? b : a;
      if ($urandom_range(0, 9) == 0) begin
         r.b_low = $urandom();
         r.b_high = $urandom();
      end
      r.c_low = random_value();
      r.c_high = random_value();
      if ($urandom_range(0, 3) != 0 && r.c_low > r.c_high) r.c_high = r.c_low;
      r.scalar = random_value();
      if (start_fresh) r.kind = ire_pkg::KIND_LOAD;
      else if ($urandom_range(0, 19) == 0) r.kind = 4'($urandom_range(11, 15));
      else r.kind = 4'($urandom_range(0, 10));
      return r;
   endfunction

   // Sends one transaction and records what the block should answer.
   task automatic send_item(input ire_pkg::req_type r, input logic has_expected,
                            input ire_pkg::rsp_type fixed_rsp);
      ire_pkg::rsp_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      predicted = next_interval(r);
      if (has_expected && predicted != fixed_rsp) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("Table row disagrees with prediction: table %h predicted %h",
                     fixed_rsp, predicted);
      end
      expected_results.push_back(has_expected ? fixed_rsp : predicted);
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_items++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4 * 32 + 20) @(posedge clock);
   endtask

   task automatic write_mode(input logic value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= 3'(4 * ire_pkg::REG_REAL_VALUED);
      pwdata <= {31'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      real_mode = value;
   endtask

   task automatic random_phase(input int unsigned count);
      int unsigned i;
      int unsigned run;
      run = 0;
      for (i = 0; i < count; i++) begin
         send_item(random_req(run == 0), 1'b0, '0);
         run = (run == 0) ? $urandom_range(1, 6) : run - 1;
      end
   endtask

   // Result checking and receiver stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("Unexpected result %h", rsp_data);
            end else begin
               if (rsp_data != expected_results[0]) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("Result mismatch: expected %h actual %h",
                              expected_results[0], rsp_data);
               end
               void'(expected_results.pop_front());
            end
         end
         if (hold_off_cycles != 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   // Run limit.
   initial begin
      #20ms;
      $display("FAIL interval_refine_engine");
      $finish;
   end

   initial begin
      int unsigned row;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      mismatch_count = 0;
      hold_off_cycles = 0;
      sent_items = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      real_mode = 1'b0;
      ivl_low = 32'd0;
      ivl_high = TopValue;
      ivl_low_open = 1'b0;
      ivl_high_open = 1'b0;
      ivl_empty = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: extremes, every kind, and the listed corner cases.
      directed_rows.push_back('{make_req(4'd11, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                                make_rsp(0, TopValue, 0, 0, 0, ire_pkg::OUT_UNCHANGED)});
      directed_rows.push_back('{make_req(ire_pkg::KIND_MIN, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                                make_rsp(0, TopValue, 0, 0, 0, ire_pkg::OUT_UNCHANGED)});
      directed_rows.push_back('{make_req(ire_pkg::KIND_MAX, 0, 0, 0, 0, 0, 0, 0, 0, TopValue),
                                1'b1, make_rsp(0, TopValue, 0, 0, 0, ire_pkg::OUT_UNCHANGED)});
      directed_rows.push_back('{make_req(ire_pkg::KIND_LOAD, 10, 5, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                                make_rsp(10, 5, 0, 0, 1, ire_pkg::OUT_EMPTY)});
      directed_rows.push_back('{make_req(ire_pkg::KIND_MUL, 1, 2, 0, 0, 1, 2, 0, 0, 0), 1'b1,
                                make_rsp(10, 5, 0, 0, 1, ire_pkg::OUT_REJECTED)});
      directed_rows.push_back('{make_req(ire_pkg::KIND_LOAD, TopValue, TopValue, 1, 0, 0, 0,
                                         0, 0, 0),
                                1'b1, make_rsp(TopValue, TopValue, 1, 0, 1, ire_pkg::OUT_EMPTY)});
      directed_rows.push_back('{make_req(ire_pkg::KIND_LOAD, 0, 0, 0, 1, 0, 0, 0, 0, 0), 1'b1,
                                make_rsp(0, 0, 0, 1, 1, ire_pkg::OUT_EMPTY)});
      directed_rows.push_back('{make_req(ire_pkg::KIND_LOAD, 0, TopValue, 1, 1, 0, 0, 0, 0, 0),
                                1'b1,
                                make_rsp(1, TopValue - 1, 0, 0, 0, ire_pkg::OUT_CHANGED)});
      directed_rows.push_back('{make_req(ire_pkg::KIND_MUL, 0, 100, 0, 0, 0, 100, 0, 0, 0),
                                1'b0, '0});
      directed_rows.push_back('{make_req(ire_pkg::KIND_DIV, 0, TopValue, 0, 0, 0, 0, 0, 0, 0),
                                1'b0, '0});
      directed_rows.push_back('{make_req(ire_pkg::KIND_DIV, 7, 100, 0, 1, 2, 3, 1, 0, 0),
                                1'b0, '0});
      directed_rows.push_back('{make_req(ire_pkg::KIND_LOAD, 0, TopValue, 0, 0, 0, 0, 0, 0, 0),
                                1'b0, '0});
      directed_rows.push_back('{make_req(ire_pkg::KIND_MULDIVK, TopValue, TopValue, 0, 0,
                                         TopValue, TopValue, 0, 0, 1), 1'b0, '0});
      directed_rows.push_back('{make_req(ire_pkg::KIND_MULDIVK, 3, 1000, 0, 0, 5, 7, 0, 0, 4),
                                1'b0, '0});
      directed_rows.push_back('{make_req(ire_pkg::KIND_MULKDIV, 10, 500, 0, 0, 3, 9, 0, 1, 7),
                                1'b0, '0});
      directed_rows.push_back('{make_req(ire_pkg::KIND_MULKDIV, 1, 2, 0, 0, 0, 0, 0, 0, 0),
                                1'b0, '0});
      directed_rows.push_back('{make_req(ire_pkg::KIND_LOAD, 5, 50, 0, 0, 0, 0, 0, 0, 0),
                                1'b0, '0});
      directed_rows.push_back('{make_req(ire_pkg::KIND_REFINE, 8, 40, 1, 1, 0, 0, 0, 0, 0),
                                1'b0, '0});
      directed_rows.push_back('{make_req(ire_pkg::KIND_SET, 0, 0, 0, 0, 0, 0, 0, 0, 20),
                                1'b0, '0});
      directed_rows.push_back('{make_req(ire_pkg::KIND_FIRST, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                                1'b0, '0});
      directed_rows.push_back('{make_req(ire_pkg::KIND_LOAD, 5, 50, 0, 0, 0, 0, 0, 0, 0),
                                1'b0, '0});
      directed_rows.push_back('{make_req(ire_pkg::KIND_LAST, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                                1'b0, '0});
      directed_rows.push_back('{make_req(4'd15, TopValue, TopValue, 1, 1, TopValue, TopValue,
                                         1, 1, TopValue), 1'b0, '0});
      for (row = 0; row < directed_rows.size(); row++)
         send_item(directed_rows[row].req, directed_rows[row].has_expected,
                   directed_rows[row].rsp);
      drain_results();

      // Real-valued mode keeps open ends, including at the edges.
      write_mode(1'b1);
      send_item(make_req(ire_pkg::KIND_LOAD, 3, 9, 1, 1, 0, 0, 0, 0, 0), 1'b1,
                make_rsp(3, 9, 1, 1, 0, ire_pkg::OUT_CHANGED));
      send_item(make_req(ire_pkg::KIND_FIRST, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
      send_item(make_req(ire_pkg::KIND_LOAD, 4, 5, 1, 1, 0, 0, 0, 0, 0), 1'b0, '0);
      send_item(make_req(ire_pkg::KIND_LAST, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
      drain_results();

      // Receiver is slower than the sender idles, then the reverse.
      send_idle_pct = 31;
      recv_idle_pct = 77;
      random_phase(RandomItems / 4);
      drain_results();
      write_mode(1'b0);
      send_idle_pct = 77;
      recv_idle_pct = 31;
      random_phase(RandomItems / 4);

      // Long receiver hold-off while items keep coming.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off_cycles = 600;
      random_phase(20);
      drain_results();
      write_mode(1'b1);
      random_phase(RandomItems / 4);
      drain_results();
      write_mode(1'b0);
      random_phase(RandomItems / 4 - 20);
      drain_results();

      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("PASS interval_refine_engine");
      end else begin
         $display("FAIL interval_refine_engine");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/ire_pkg.sv
sv/interval_refine_engine.sv
tb/interval_refine_engine_test.sv
